// File: rtl/wgm_pkg.sv
// Shared types and constants for the wildcard glob match unit.
// No dependencies; the files that use it refer to it by scoped names.
package wgm_pkg;

	localparam logic [7:0] WC_END  = 8'h00;
	localparam logic [7:0] WC_STAR = 8'h2A;
	localparam logic [7:0] WC_ANY  = 8'h3F;

	localparam logic CMD_PATTERN = 1'b0;
	localparam logic CMD_SUBJECT = 1'b1;

	typedef struct packed {
		logic       command;
		logic [7:0] ch;
	} req_t;

	typedef struct packed {
		logic matched;
		logic too_long;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_HOLD
	} state_t;

	typedef enum logic [2:0] {
		DEC_ADV,
		DEC_STAR,
		DEC_BACK,
		DEC_HIT,
		DEC_MISS
	} dec_t;

endpackage

// File: rtl/wgm_stream_if.sv
// Valid/ready channel carrying one payload per transfer.
// The payload type comes from wgm_pkg at the point of instantiation.
interface wgm_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// File: rtl/wildcard_glob_match_unit.sv
// Wildcard glob matcher with a stored pattern: top level.
// Loading takes one transfer per cycle while the unit is idle; requests are held off otherwise.
// A subject terminator starts the match walk (skipped when a store overflowed), which runs
// one step per cycle from the two store read ports; the result is then registered for rsp.
// Reset clears counts, flags and the sequencer and leaves an empty pattern; the byte
// memories are not cleared. Depends on wgm_pkg, wgm_stream_if, wgm_store, wgm_eval.
module wildcard_glob_match_unit #(
	parameter int MAX_LEN = 64
) (
	input logic         clk,
	input logic         arst_n,
	wgm_stream_if.sink   req,
	wgm_stream_if.source rsp
);
	localparam int AW = $clog2(MAX_LEN);
	localparam int CW = $clog2(MAX_LEN + 1);

	logic          acc, start, too_long, idle, clear;
	logic [AW-1:0] pat_addr, sub_addr;
	logic [7:0]    pat_data, sub_data;
	logic [CW-1:0] pat_count, sub_count;
	wgm_pkg::req_t item;
	wgm_pkg::rsp_t result;

	assign req.ready   = idle;
	assign acc         = req.valid && req.ready;
	assign item        = req.payload;
	assign rsp.payload = result;

	wgm_store #(.MAX_LEN(MAX_LEN)) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.item      (item),
		.clear     (clear),
		.pat_addr  (pat_addr),
		.sub_addr  (sub_addr),
		.pat_data  (pat_data),
		.sub_data  (sub_data),
		.pat_count (pat_count),
		.sub_count (sub_count),
		.too_long  (too_long),
		.start     (start)
	);

	wgm_eval #(.MAX_LEN(MAX_LEN)) u_eval (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.too_long    (too_long),
		.pat_count   (pat_count),
		.sub_count   (sub_count),
		.pat_data    (pat_data),
		.sub_data    (sub_data),
		.pat_addr    (pat_addr),
		.sub_addr    (sub_addr),
		.idle        (idle),
		.clear       (clear),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.rsp_payload (result)
	);

endmodule

// File: rtl/wgm_store.sv
// Pattern and subject byte memories with their fill counts and overflow flags.
// Depends on wgm_pkg for the terminator and command codes.
module wgm_store #(
	parameter int MAX_LEN = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         acc,
	input  wgm_pkg::req_t                item,
	input  logic                         clear,
	input  logic [$clog2(MAX_LEN)-1:0]   pat_addr,
	input  logic [$clog2(MAX_LEN)-1:0]   sub_addr,
	output logic [7:0]                   pat_data,
	output logic [7:0]                   sub_data,
	output logic [$clog2(MAX_LEN+1)-1:0] pat_count,
	output logic [$clog2(MAX_LEN+1)-1:0] sub_count,
	output logic                         too_long,
	output logic                         start
);
	localparam int AW = $clog2(MAX_LEN);
	localparam int CW = $clog2(MAX_LEN + 1);
	localparam logic [CW-1:0] LIMIT = CW'(MAX_LEN);

	logic [7:0]    pat_mem [MAX_LEN];
	logic [7:0]    sub_mem [MAX_LEN];
	logic [CW-1:0] pat_cnt_q, sub_cnt_q;
	logic          pat_closed_q, pat_ovf_q, sub_ovf_q;
	logic [CW-1:0] pat_base;
	logic          pat_ovf_base, pat_room, sub_room;
	logic          pat_acc, sub_acc, is_end;
	logic          pat_we, sub_we;

	always_comb begin
		// A pattern byte that arrives after a closed pattern starts a fresh one.
		pat_base     = pat_closed_q ? '0 : pat_cnt_q;
		pat_ovf_base = pat_closed_q ? 1'b0 : pat_ovf_q;
		pat_room     = pat_base < LIMIT;
		sub_room     = sub_cnt_q < LIMIT;
		is_end       = item.ch == wgm_pkg::WC_END;
		pat_acc      = acc && item.command == wgm_pkg::CMD_PATTERN;
		sub_acc      = acc && item.command == wgm_pkg::CMD_SUBJECT;
		pat_we       = pat_acc && !is_end && pat_room;
		sub_we       = sub_acc && !is_end && sub_room;
		start        = sub_acc && is_end;
		too_long     = pat_ovf_q || sub_ovf_q;
		pat_count    = pat_cnt_q;
		sub_count    = sub_cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_cnt_q    <= '0;
			pat_closed_q <= 1'b1;
			pat_ovf_q    <= 1'b0;
			sub_cnt_q    <= '0;
			sub_ovf_q    <= 1'b0;
		end else begin
			if (pat_acc) begin
				if (is_end) begin
					pat_closed_q <= 1'b1;
					pat_cnt_q    <= pat_base;
					pat_ovf_q    <= pat_ovf_base;
				end else begin
					pat_closed_q <= 1'b0;
					pat_cnt_q    <= pat_room ? pat_base + CW'(1) : pat_base;
					pat_ovf_q    <= pat_ovf_base || !pat_room;
				end
			end
			if (sub_acc) begin
				pat_closed_q <= 1'b1;
				if (!is_end) begin
					if (sub_room) begin
						sub_cnt_q <= sub_cnt_q + CW'(1);
					end else begin
						sub_ovf_q <= 1'b1;
					end
				end
			end
			if (clear) begin
				sub_cnt_q <= '0;
				sub_ovf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pat_we) begin
			pat_mem[pat_base[AW-1:0]] <= item.ch;
		end
		pat_data <= pat_mem[pat_addr];
	end

	always_ff @(posedge clk) begin
		if (sub_we) begin
			sub_mem[sub_cnt_q[AW-1:0]] <= item.ch;
		end
		sub_data <= sub_mem[sub_addr];
	end

endmodule

// File: rtl/wgm_eval.sv
// Backtracking match sequencer: one comparison step per cycle over the stores,
// plus the result register. Depends on wgm_pkg for codes, states and types.
module wgm_eval #(
	parameter int MAX_LEN = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         too_long,
	input  logic [$clog2(MAX_LEN+1)-1:0] pat_count,
	input  logic [$clog2(MAX_LEN+1)-1:0] sub_count,
	input  logic [7:0]                   pat_data,
	input  logic [7:0]                   sub_data,
	output logic [$clog2(MAX_LEN)-1:0]   pat_addr,
	output logic [$clog2(MAX_LEN)-1:0]   sub_addr,
	output logic                         idle,
	output logic                         clear,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output wgm_pkg::rsp_t                rsp_payload
);
	localparam int AW = $clog2(MAX_LEN);
	localparam int CW = $clog2(MAX_LEN + 1);

	wgm_pkg::state_t state_q, state_d;
	wgm_pkg::dec_t   dec;
	wgm_pkg::rsp_t   res_q, rsp_q;
	logic [CW-1:0]   pi_q, si_q, star_p_q, star_s_q;
	logic [CW-1:0]   pi_d, si_d, star_p_d, star_s_d;
	logic            have_star_q, have_star_d;
	logic            rsp_valid_q, release_ok;
	logic [7:0]      p, s;

	// Positions at or past a count read as the terminator.
	always_comb begin
		p = (pi_q < pat_count) ? pat_data : wgm_pkg::WC_END;
		s = (si_q < sub_count) ? sub_data : wgm_pkg::WC_END;
		priority if (p == s && s == wgm_pkg::WC_END) begin
			dec = wgm_pkg::DEC_HIT;
		end else if (p == s) begin
			dec = wgm_pkg::DEC_ADV;
		end else if (s != wgm_pkg::WC_END && p == wgm_pkg::WC_ANY) begin
			dec = wgm_pkg::DEC_ADV;
		end else if (p == wgm_pkg::WC_STAR) begin
			dec = wgm_pkg::DEC_STAR;
		end else if (have_star_q && star_s_q < sub_count) begin
			dec = wgm_pkg::DEC_BACK;
		end else begin
			dec = wgm_pkg::DEC_MISS;
		end
	end

	assign release_ok = !rsp_valid_q || rsp_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wgm_pkg::ST_IDLE: begin
				if (start) begin
					state_d = too_long ? wgm_pkg::ST_HOLD : wgm_pkg::ST_STEP;
				end
			end
			wgm_pkg::ST_STEP: begin
				if (dec == wgm_pkg::DEC_HIT || dec == wgm_pkg::DEC_MISS) begin
					state_d = wgm_pkg::ST_HOLD;
				end
			end
			wgm_pkg::ST_HOLD: begin
				if (release_ok) begin
					state_d = wgm_pkg::ST_IDLE;
				end
			end
			default: state_d = wgm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pi_d        = '0;
		si_d        = '0;
		star_p_d    = star_p_q;
		star_s_d    = star_s_q;
		have_star_d = have_star_q;
		if (state_q == wgm_pkg::ST_IDLE) begin
			have_star_d = 1'b0;
		end else if (state_q == wgm_pkg::ST_STEP) begin
			pi_d = pi_q;
			si_d = si_q;
			unique case (dec)
				wgm_pkg::DEC_ADV: begin
					pi_d = pi_q + CW'(1);
					si_d = si_q + CW'(1);
				end
				wgm_pkg::DEC_STAR: begin
					pi_d        = pi_q + CW'(1);
					star_p_d    = pi_q + CW'(1);
					star_s_d    = si_q;
					have_star_d = 1'b1;
				end
				wgm_pkg::DEC_BACK: begin
					star_s_d = star_s_q + CW'(1);
					si_d     = star_s_q + CW'(1);
					pi_d     = star_p_q;
				end
				default: begin
				end
			endcase
		end
		// The memories are read at the next step's positions, so data is ready then.
		pat_addr = pi_d[AW-1:0];
		sub_addr = si_d[AW-1:0];
		idle     = state_q == wgm_pkg::ST_IDLE;
		clear    = state_q == wgm_pkg::ST_HOLD && release_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wgm_pkg::ST_IDLE;
			have_star_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			have_star_q <= have_star_d;
			if (clear) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pi_q     <= pi_d;
		si_q     <= si_d;
		star_p_q <= star_p_d;
		star_s_q <= star_s_d;
		if (state_q == wgm_pkg::ST_IDLE) begin
			res_q.matched  <= 1'b0;
			res_q.too_long <= too_long;
		end else if (state_q == wgm_pkg::ST_STEP) begin
			res_q.matched <= dec == wgm_pkg::DEC_HIT;
		end
		if (clear) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign rsp_payload = rsp_q;

endmodule

// File: dv/tb_wildcard_glob_match_unit.sv
// Self-checking testbench for wildcard_glob_match_unit: random and directed byte streams
// on the req channel, verdicts on the rsp channel checked against an in-bench glob matcher.
// Depends on wgm_pkg, wgm_stream_if and the RTL of the unit.
module tb_wildcard_glob_match_unit;

	localparam int MAX_LEN = 64;
	localparam int N_RANDOM = 1750;
	localparam int SETTLE = (MAX_LEN + 2) * (MAX_LEN + 2);

	typedef struct packed {
		logic drain;
		wgm_pkg::req_t item;
	} stim_t;

	logic clk;
	logic arst_n;

	wgm_stream_if #(.payload_t(wgm_pkg::req_t)) req_if ();
	wgm_stream_if #(.payload_t(wgm_pkg::rsp_t)) rsp_if ();

	wildcard_glob_match_unit #(.MAX_LEN(MAX_LEN)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	// Shadow state of the matcher.
	logic [7:0] pat_mem[MAX_LEN];
	int pat_len = 0;
	bit pat_closed = 1'b1;
	bit pat_ovf = 1'b0;
	logic [7:0] subj_mem[MAX_LEN];
	int subj_len = 0;
	bit subj_ovf = 1'b0;

	wgm_pkg::rsp_t verdicts[$];
	stim_t stim_q[$];
	logic [7:0] pat_shadow[$];
	bit drain_next = 1'b0;
	int issued = 0;
	int accepted = 0;
	int third = 1;
	int errors = 0;
	longint cycles = 0;
	longint cycle_limit = 64'd1000000;
	longint budget = 0;
	wgm_pkg::rsp_t got;
	wgm_pkg::rsp_t want;

	function automatic logic [7:0] pat_byte(int i);
		return (i < pat_len) ? pat_mem[i] : wgm_pkg::WC_END;
	endfunction

	function automatic logic [7:0] subj_byte(int i);
		return (i < subj_len) ? subj_mem[i] : wgm_pkg::WC_END;
	endfunction

	// Backtracking walk that remembers only the latest star. Equal bytes are
	// consumed before wildcards are looked at, so a literal star or question
	// mark in the subject eats the same byte in the pattern.
	function automatic bit glob_walk();
		int pi;
		int si;
		int sp;
		int ss;
		bit star;
		bit done;
		bit hit;
		pi = 0;
		si = 0;
		sp = 0;
		ss = 0;
		star = 1'b0;
		done = 1'b0;
		hit = 1'b0;
		while (!done) begin
			if (pat_byte(pi) == subj_byte(si)) begin
				if (subj_byte(si) == wgm_pkg::WC_END) begin
					hit = 1'b1;
					done = 1'b1;
				end else begin
					pi++;
					si++;
				end
			end else if (subj_byte(si) != wgm_pkg::WC_END
					&& pat_byte(pi) == wgm_pkg::WC_ANY) begin
				pi++;
				si++;
			end else if (pat_byte(pi) == wgm_pkg::WC_STAR) begin
				pi++;
				sp = pi;
				ss = si;
				star = 1'b1;
			end else if (star && subj_byte(ss) != wgm_pkg::WC_END) begin
				ss++;
				si = ss;
				pi = sp;
			end else begin
				done = 1'b1;
			end
		end
		return hit;
	endfunction

	task automatic predict_verdict(input wgm_pkg::req_t r);
		wgm_pkg::rsp_t v;
		if (r.command == wgm_pkg::CMD_PATTERN) begin
			if (pat_closed) begin
				pat_len = 0;
				pat_ovf = 1'b0;
				pat_closed = 1'b0;
			end
			if (r.ch == wgm_pkg::WC_END) begin
				pat_closed = 1'b1;
			end else if (pat_len < MAX_LEN) begin
				pat_mem[pat_len] = r.ch;
				pat_len++;
			end else begin
				pat_ovf = 1'b1;
			end
		end else begin
			pat_closed = 1'b1;
			if (r.ch != wgm_pkg::WC_END) begin
				if (subj_len < MAX_LEN) begin
					subj_mem[subj_len] = r.ch;
					subj_len++;
				end else begin
					subj_ovf = 1'b1;
				end
			end else begin
				v.too_long = pat_ovf | subj_ovf;
				v.matched = v.too_long ? 1'b0 : glob_walk();
				verdicts.push_back(v);
				subj_len = 0;
				subj_ovf = 1'b0;
			end
		end
	endtask

	// Stimulus construction. The cycle budget grows with each byte and with the
	// worst-case walk behind each subject terminator.
	task automatic push_byte(input logic cmd, input logic [7:0] c);
		stim_t s;
		s.drain = drain_next;
		s.item.command = cmd;
		s.item.ch = c;
		stim_q.push_back(s);
		drain_next = 1'b0;
		budget += 64;
		if (cmd == wgm_pkg::CMD_SUBJECT && c == wgm_pkg::WC_END)
			budget += SETTLE + 256;
	endtask

	function automatic logic [7:0] rand_glyph();
		logic [7:0] c;
		case ($urandom_range(0, 9))
			0, 1, 2: c = 8'h61;
			3, 4: c = 8'h62;
			5: c = wgm_pkg::WC_STAR;
			6: c = wgm_pkg::WC_ANY;
			default: c = 8'($urandom_range(1, 255));
		endcase
		return c;
	endfunction

	task automatic gen_pattern();
		int n;
		logic [7:0] c;
		n = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 7);
		pat_shadow.delete();
		for (int i = 0; i < n; i++) begin
			c = rand_glyph();
			pat_shadow.push_back(c);
			push_byte(wgm_pkg::CMD_PATTERN, c);
		end
		// Now and then the pattern is left open and the subject closes it.
		if ($urandom_range(0, 7) != 0)
			push_byte(wgm_pkg::CMD_PATTERN, wgm_pkg::WC_END);
	endtask

	task automatic gen_subject();
		int mode;
		int n;
		int cut;
		mode = $urandom_range(0, 9);
		if (mode < 6) begin
			// Build a subject that the current pattern should accept, with one extra byte in mode 5.
			foreach (pat_shadow[i]) begin
				if (pat_shadow[i] == wgm_pkg::WC_STAR) begin
					repeat ($urandom_range(0, 3))
						push_byte(wgm_pkg::CMD_SUBJECT, rand_glyph());
				end else if (pat_shadow[i] == wgm_pkg::WC_ANY) begin
					push_byte(wgm_pkg::CMD_SUBJECT, 8'($urandom_range(1, 255)));
				end else begin
					push_byte(wgm_pkg::CMD_SUBJECT, pat_shadow[i]);
				end
			end
			if (mode == 5)
				push_byte(wgm_pkg::CMD_SUBJECT, rand_glyph());
		end else begin
			n = (mode == 9 && $urandom_range(0, 2) == 0) ? $urandom_range(60, 70)
				: $urandom_range(0, 9);
			cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n) : -1;
			for (int i = 0; i < n; i++) begin
				// A new pattern in the middle of a subject leaves the subject intact.
				if (i == cut)
					gen_pattern();
				push_byte(wgm_pkg::CMD_SUBJECT, rand_glyph());
			end
		end
		push_byte(wgm_pkg::CMD_SUBJECT, wgm_pkg::WC_END);
	endtask

	function automatic int load_phase();
		return (accepted < third) ? 0 : (accepted < 2 * third) ? 1 : 2;
	endfunction

	function automatic int send_idle_pct();
		case (load_phase())
			0: return 36;
			1: return 59;
			default: return 0;
		endcase
	endfunction

	function automatic int recv_idle_pct();
		case (load_phase())
			0: return 59;
			1: return 36;
			default: return 0;
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		req_if.valid = 1'b0;
		req_if.payload = '0;
		rsp_if.ready = 1'b0;
	end

	// Request driver: a new transfer is offered only once the previous one is taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else if (issued == accepted) begin
			if (stim_q.size() != 0 && !(stim_q[0].drain && verdicts.size() != 0)
					&& $urandom_range(0, 99) >= send_idle_pct()) begin
				req_if.payload <= stim_q[0].item;
				req_if.valid <= 1'b1;
				issued++;
				void'(stim_q.pop_front());
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n)
			rsp_if.ready <= 1'b0;
		else
			rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct());
	end

	// Monitor: predict on each request transfer, check each response transfer.
	always @(posedge clk) begin
		if (arst_n && req_if.valid && req_if.ready) begin
			predict_verdict(req_if.payload);
			accepted++;
		end
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got = rsp_if.payload;
			if (verdicts.size() == 0) begin
				$display("%0t: unexpected result matched=%0b too_long=%0b",
					$time, got.matched, got.too_long);
				errors++;
			end else begin
				want = verdicts.pop_front();
				if (got.matched !== want.matched) begin
					$display("%0t: matched expected %0b actual %0b",
						$time, want.matched, got.matched);
					errors++;
				end
				if (got.too_long !== want.too_long) begin
					$display("%0t: too_long expected %0b actual %0b",
						$time, want.too_long, got.too_long);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > cycle_limit) begin
			$display("%0t: no completion within %0d cycles", $time, cycle_limit);
			$display("wildcard_glob_match_unit verification failed");
			$finish;
		end
	end

	initial begin
		// Directed: empty pattern after reset.
		push_byte(wgm_pkg::CMD_SUBJECT, wgm_pkg::WC_END);
		push_byte(wgm_pkg::CMD_SUBJECT, 8'hFF);
		push_byte(wgm_pkg::CMD_SUBJECT, wgm_pkg::WC_END);
		// Open pattern "?*\x01" closed by the first subject byte.
		push_byte(wgm_pkg::CMD_PATTERN, wgm_pkg::WC_ANY);
		push_byte(wgm_pkg::CMD_PATTERN, wgm_pkg::WC_STAR);
		push_byte(wgm_pkg::CMD_PATTERN, 8'h01);
		push_byte(wgm_pkg::CMD_SUBJECT, 8'h80);
		push_byte(wgm_pkg::CMD_SUBJECT, 8'h01);
		push_byte(wgm_pkg::CMD_SUBJECT, wgm_pkg::WC_END);
		// A literal star in the subject consumes the pattern star.
		push_byte(wgm_pkg::CMD_SUBJECT, wgm_pkg::WC_STAR);
		push_byte(wgm_pkg::CMD_SUBJECT, wgm_pkg::WC_STAR);
		push_byte(wgm_pkg::CMD_SUBJECT, 8'h01);
		push_byte(wgm_pkg::CMD_SUBJECT, wgm_pkg::WC_END);
		// A lone terminator on a closed pattern stores the empty pattern.
		push_byte(wgm_pkg::CMD_PATTERN, wgm_pkg::WC_END);
		push_byte(wgm_pkg::CMD_SUBJECT, wgm_pkg::WC_END);
		push_byte(wgm_pkg::CMD_PATTERN, 8'hFF);
		push_byte(wgm_pkg::CMD_PATTERN, wgm_pkg::WC_END);
		push_byte(wgm_pkg::CMD_SUBJECT, 8'hFF);
		push_byte(wgm_pkg::CMD_SUBJECT, wgm_pkg::WC_END);
		push_byte(wgm_pkg::CMD_PATTERN, wgm_pkg::WC_STAR);
		push_byte(wgm_pkg::CMD_PATTERN, wgm_pkg::WC_END);
		push_byte(wgm_pkg::CMD_SUBJECT, 8'h7F);
		push_byte(wgm_pkg::CMD_SUBJECT, wgm_pkg::WC_END);

		// The random part opens with the sender waiting for all verdicts.
		drain_next = 1'b1;
		while (stim_q.size() < N_RANDOM + 23) begin
			if ($urandom_range(0, 4) == 0)
				gen_pattern();
			if ($urandom_range(0, 99) == 0)
				drain_next = 1'b1;
			gen_subject();
		end
		third = stim_q.size() / 3;
		cycle_limit = 3 * budget + 20000;

		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (stim_q.size() != 0 || issued != accepted || verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (errors == 0)
			$display("wildcard_glob_match_unit verification clean");
		else
			$display("wildcard_glob_match_unit verification failed");
		$finish;
	end

endmodule
